[src/omd_pkg.sv]
package omd_pkg;

  localparam int MainCount  = 125;
  localparam int ExtCount   = 25;
  localparam int MainIdxW   = 7;
  localparam int ExtIdxW    = 5;
  localparam int InstW      = 16;
  localparam int GroupSize  = 8;

  localparam logic [3:0]       SevenNibble = 4'h3;
  localparam logic [InstW-1:0] SevenMask   = 16'h007f;
  localparam logic [InstW-1:0] EightMask   = 16'h00ff;

  typedef struct packed {
    logic [InstW-1:0] pat;
    logic [InstW-1:0] msk;
  } pair_t;

  typedef struct packed {
    logic grp;
    logic fin;
  } stage_en_t;

  localparam pair_t MainTab [MainCount] = '{
    '{16'h0000, 16'hfffc}, '{16'h0004, 16'hfffc}, '{16'h0008, 16'hfffc}, '{16'h000c, 16'hfffc},
    '{16'h0010, 16'hfff0}, '{16'h0021, 16'hffff}, '{16'h02d0, 16'hfff0}, '{16'h02f0, 16'hfff0},
    '{16'h02b0, 16'hfff0}, '{16'h0270, 16'hfff0}, '{16'h0290, 16'hfff0}, '{16'h1700, 16'hff10},
    '{16'h1710, 16'hff10}, '{16'h1200, 16'hff00}, '{16'h1300, 16'hff00}, '{16'h1400, 16'hfec0},
    '{16'h1440, 16'hfec0}, '{16'h1480, 16'hfec0}, '{16'h14c0, 16'hfec0}, '{16'h02ca, 16'hffff},
    '{16'h02cb, 16'hffff}, '{16'h0080, 16'hffe0}, '{16'h00c0, 16'hffe0}, '{16'h00e0, 16'hffe0},
    '{16'h1c00, 16'hfc00}, '{16'h1600, 16'hff00}, '{16'h0400, 16'hfe00}, '{16'h0600, 16'hfe00},
    '{16'h0800, 16'hf800}, '{16'h0200, 16'hfeff}, '{16'h0220, 16'hfeff}, '{16'h0240, 16'hfeff},
    '{16'h0260, 16'hfeff}, '{16'h0280, 16'hfeff}, '{16'h02a0, 16'hfeff}, '{16'h02c0, 16'hfeff},
    '{16'h0210, 16'hfefc}, '{16'h0214, 16'hfefc}, '{16'h0218, 16'hfefc}, '{16'h021c, 16'hfefc},
    '{16'h0040, 16'hffe0}, '{16'h0060, 16'hffe0}, '{16'h1000, 16'hff00}, '{16'h1100, 16'hff00},
    '{16'h1800, 16'hff80}, '{16'h1880, 16'hff80}, '{16'h1900, 16'hff80}, '{16'h1980, 16'hff80},
    '{16'h1a00, 16'hff80}, '{16'h1a80, 16'hff80}, '{16'h1b00, 16'hff80}, '{16'h1b80, 16'hff80},
    '{16'h2000, 16'hf800}, '{16'h2800, 16'hfe00}, '{16'h2c00, 16'hfc00},
    '{16'h3000, 16'hfc80}, '{16'h3400, 16'hfc80}, '{16'h3800, 16'hfc80}, '{16'h3c00, 16'hfe80},
    '{16'h3e00, 16'hfe80}, '{16'h3080, 16'hfe80}, '{16'h3280, 16'hfe80}, '{16'h3480, 16'hfc80},
    '{16'h3880, 16'hfc80}, '{16'h3c80, 16'hfe80}, '{16'h3e80, 16'hfe80},
    '{16'h4000, 16'hf800}, '{16'h4800, 16'hfc00}, '{16'h4c00, 16'hfe00}, '{16'h4e00, 16'hfe00},
    '{16'h5000, 16'hf800}, '{16'h5800, 16'hfc00}, '{16'h5c00, 16'hfe00}, '{16'h5e00, 16'hfe00},
    '{16'h6000, 16'hf800}, '{16'h6800, 16'hfc00}, '{16'h6c00, 16'hfe00}, '{16'h6e00, 16'hfe00},
    '{16'h7000, 16'hfc00}, '{16'h7400, 16'hfe00}, '{16'h7600, 16'hfe00}, '{16'h7800, 16'hfe00},
    '{16'h7a00, 16'hfe00}, '{16'h7c00, 16'hfe00}, '{16'h7e00, 16'hfe00},
    '{16'h8000, 16'hf700}, '{16'h8100, 16'hf700}, '{16'h8200, 16'hff00}, '{16'h8300, 16'hff00},
    '{16'h8400, 16'hff00}, '{16'h8500, 16'hff00}, '{16'h8600, 16'hfe00}, '{16'h8a00, 16'hff00},
    '{16'h8b00, 16'hff00}, '{16'h8c00, 16'hff00}, '{16'h8d00, 16'hff00}, '{16'h8e00, 16'hff00},
    '{16'h8f00, 16'hff00},
    '{16'h9000, 16'hf700}, '{16'h9100, 16'hf700}, '{16'h9200, 16'hf600}, '{16'h9400, 16'hf600},
    '{16'h9600, 16'hf600},
    '{16'ha000, 16'he700}, '{16'ha100, 16'hf700}, '{16'ha200, 16'he600}, '{16'ha400, 16'he600},
    '{16'ha600, 16'he600}, '{16'hb100, 16'hf700},
    '{16'hc000, 16'he700}, '{16'hc100, 16'he700}, '{16'hc200, 16'he600}, '{16'hc400, 16'he600},
    '{16'hc600, 16'he600},
    '{16'he000, 16'hfc00}, '{16'he400, 16'hfc00}, '{16'he800, 16'hfc00}, '{16'hec00, 16'hfc00},
    '{16'hf000, 16'hfe00}, '{16'hf200, 16'hfe00}, '{16'hf400, 16'hfe00}, '{16'hf600, 16'hfe00},
    '{16'hf800, 16'hfc00}, '{16'hfc00, 16'hfe00}, '{16'hfe00, 16'hfe00}
  };

  localparam pair_t ExtTab [ExtCount] = '{
    '{16'h0000, 16'h00fc}, '{16'h0004, 16'h00fc}, '{16'h0008, 16'h00fc}, '{16'h000c, 16'h00fc},
    '{16'h0010, 16'h00f0}, '{16'h0020, 16'h00e4}, '{16'h0024, 16'h00e4}, '{16'h0040, 16'h00c4},
    '{16'h0044, 16'h00c4}, '{16'h0080, 16'h00ce}, '{16'h0082, 16'h00ce}, '{16'h0084, 16'h00ce},
    '{16'h0086, 16'h00ce}, '{16'h0088, 16'h00ce}, '{16'h008a, 16'h00ce}, '{16'h008c, 16'h00ce},
    '{16'h008e, 16'h00ce}, '{16'h00c3, 16'h00cf}, '{16'h00c7, 16'h00cf}, '{16'h00cb, 16'h00cf},
    '{16'h00cf, 16'h00cf}, '{16'h00c0, 16'h00cc}, '{16'h00c4, 16'h00cc}, '{16'h00c8, 16'h00cc},
    '{16'h00cc, 16'h00cc}
  };

endpackage

[src/omd_prio_enc.sv]
module omd_prio_enc
  import omd_pkg::*;
#(
  parameter int Entries = MainCount,
  parameter int IdxW    = MainIdxW
) (
  input  logic               clk_i,
  input  stage_en_t          en_i,
  input  logic [Entries-1:0] hit_i,
  output logic [IdxW-1:0]    idx_o,
  output logic               matched_o
);

  localparam int Groups  = (Entries + GroupSize - 1) / GroupSize;
  localparam int PadW    = Groups * GroupSize;
  localparam int LocW    = $clog2(GroupSize);
  localparam int GrpW    = (Groups > 1) ? $clog2(Groups) : 1;

  logic [PadW-1:0]              hit_pad;
  logic [Groups-1:0]            any_d, any_q;
  logic [Groups-1:0][LocW-1:0]  loc_d, loc_q;
  logic [GrpW-1:0]              grp_sel;
  logic [IdxW-1:0]              idx_d, idx_q;
  logic                         matched_d, matched_q;

  assign hit_pad = PadW'(hit_i);

  // The lowest set position of each group of eight wins inside that group.
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      any_d[g] = |hit_pad[g*GroupSize +: GroupSize];
      loc_d[g] = '0;
      for (int i = GroupSize - 1; i >= 0; i--) begin
        if (hit_pad[g*GroupSize + i]) begin
          loc_d[g] = LocW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.grp) begin
      any_q <= any_d;
      loc_q <= loc_d;
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = Groups - 1; g >= 0; g--) begin
      if (any_q[g]) begin
        grp_sel = GrpW'(g);
      end
    end
    matched_d = |any_q;
    idx_d     = matched_d ? IdxW'({grp_sel, loc_q[grp_sel]}) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      idx_q     <= idx_d;
      matched_q <= matched_d;
    end
  end

  assign idx_o     = idx_q;
  assign matched_o = matched_q;

endmodule

[src/dsp_opcode_mask_match_decoder.sv]
// Mask-match decoder for 16-bit DSP instruction words.
// Input channel: in_valid_i, instruction_i, with in_stall_o driven back. A beat is
// taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with main_entry_o, main_matched_o, ext_entry_o,
// ext_matched_o and seven_bit_ext_o; the receiver holds it with out_stall_i.
// Each beat passes four register stages: input capture, table compare,
// per-group priority and final group select. A result appears on out_valid_o
// three cycles after the edge at which its beat is taken, and a new beat may be
// taken every cycle, so throughput is one instruction per cycle.
// When the receiver stalls, the output stage holds its beat and the stages
// before it keep filling until each holds a beat; only then is in_stall_o
// raised. Nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards and no state
// other than the beats in flight is kept.
module dsp_opcode_mask_match_decoder
  import omd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InstW-1:0]    instruction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MainIdxW-1:0] main_entry_o,
  output logic                main_matched_o,
  output logic [ExtIdxW-1:0]  ext_entry_o,
  output logic                ext_matched_o,
  output logic                seven_bit_ext_o
);

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic [InstW-1:0]     inst_q;
  logic                 seven_d, seven2_q, seven3_q, seven4_q;
  logic [InstW-1:0]     ext_bits;
  logic [MainCount-1:0] main_hit_d, main_hit_q;
  logic [ExtCount-1:0]  ext_hit_d, ext_hit_q;
  stage_en_t            enc_en;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) inst_q <= instruction_i;
  end

  assign seven_d  = inst_q[InstW-1 -: 4] == SevenNibble;
  assign ext_bits = inst_q & (seven_d ? SevenMask : EightMask);

  always_comb begin
    for (int k = 0; k < MainCount; k++) begin
      main_hit_d[k] = (inst_q & MainTab[k].msk) == MainTab[k].pat;
    end
    for (int k = 0; k < ExtCount; k++) begin
      ext_hit_d[k] = (ext_bits & ExtTab[k].msk) == ExtTab[k].pat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      main_hit_q <= main_hit_d;
      ext_hit_q  <= ext_hit_d;
      seven2_q   <= seven_d;
    end
    if (rdy3) seven3_q <= seven2_q;
    if (rdy4) seven4_q <= seven3_q;
  end

  assign enc_en.grp = rdy3;
  assign enc_en.fin = rdy4;

  omd_prio_enc #(
    .Entries (MainCount),
    .IdxW    (MainIdxW)
  ) u_main_enc (
    .clk_i     (clk_i),
    .en_i      (enc_en),
    .hit_i     (main_hit_q),
    .idx_o     (main_entry_o),
    .matched_o (main_matched_o)
  );

  omd_prio_enc #(
    .Entries (ExtCount),
    .IdxW    (ExtIdxW)
  ) u_ext_enc (
    .clk_i     (clk_i),
    .en_i      (enc_en),
    .hit_i     (ext_hit_q),
    .idx_o     (ext_entry_o),
    .matched_o (ext_matched_o)
  );

  assign out_valid_o     = v4_q;
  assign seven_bit_ext_o = seven4_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled while a stage is empty");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted beat did not reach the first stage");

  a_main_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !main_matched_o) |-> (main_entry_o == '0))
    else $error("unmatched main result carries a non-zero entry");

  a_ext_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ext_matched_o) |-> (ext_entry_o == '0))
    else $error("unmatched extension result carries a non-zero entry");

  a_entry_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((main_entry_o < MainIdxW'(MainCount)) &&
                     (ext_entry_o < ExtIdxW'(ExtCount))))
    else $error("entry index beyond table size");

endmodule

[sim/tb_dsp_opcode_mask_match_decoder.sv]
`timescale 1ns / 1ps

module tb_dsp_opcode_mask_match_decoder;
  import omd_pkg::*;

  typedef struct packed {
    logic [MainIdxW-1:0] main_entry;
    logic                main_matched;
    logic [ExtIdxW-1:0]  ext_entry;
    logic                ext_matched;
    logic                seven_bit;
  } decode_t;

  // Each rule is {pattern, mask}; the lowest index that matches wins.
  localparam logic [31:0] MainRules [125] = '{
    32'h0000_fffc, 32'h0004_fffc, 32'h0008_fffc, 32'h000c_fffc,
    32'h0010_fff0, 32'h0021_ffff, 32'h02d0_fff0, 32'h02f0_fff0,
    32'h02b0_fff0, 32'h0270_fff0, 32'h0290_fff0, 32'h1700_ff10,
    32'h1710_ff10, 32'h1200_ff00, 32'h1300_ff00, 32'h1400_fec0,
    32'h1440_fec0, 32'h1480_fec0, 32'h14c0_fec0, 32'h02ca_ffff,
    32'h02cb_ffff, 32'h0080_ffe0, 32'h00c0_ffe0, 32'h00e0_ffe0,
    32'h1c00_fc00, 32'h1600_ff00, 32'h0400_fe00, 32'h0600_fe00,
    32'h0800_f800, 32'h0200_feff, 32'h0220_feff, 32'h0240_feff,
    32'h0260_feff, 32'h0280_feff, 32'h02a0_feff, 32'h02c0_feff,
    32'h0210_fefc, 32'h0214_fefc, 32'h0218_fefc, 32'h021c_fefc,
    32'h0040_ffe0, 32'h0060_ffe0, 32'h1000_ff00, 32'h1100_ff00,
    32'h1800_ff80, 32'h1880_ff80, 32'h1900_ff80, 32'h1980_ff80,
    32'h1a00_ff80, 32'h1a80_ff80, 32'h1b00_ff80, 32'h1b80_ff80,
    32'h2000_f800, 32'h2800_fe00, 32'h2c00_fc00,
    32'h3000_fc80, 32'h3400_fc80, 32'h3800_fc80, 32'h3c00_fe80,
    32'h3e00_fe80, 32'h3080_fe80, 32'h3280_fe80, 32'h3480_fc80,
    32'h3880_fc80, 32'h3c80_fe80, 32'h3e80_fe80,
    32'h4000_f800, 32'h4800_fc00, 32'h4c00_fe00, 32'h4e00_fe00,
    32'h5000_f800, 32'h5800_fc00, 32'h5c00_fe00, 32'h5e00_fe00,
    32'h6000_f800, 32'h6800_fc00, 32'h6c00_fe00, 32'h6e00_fe00,
    32'h7000_fc00, 32'h7400_fe00, 32'h7600_fe00, 32'h7800_fe00,
    32'h7a00_fe00, 32'h7c00_fe00, 32'h7e00_fe00,
    32'h8000_f700, 32'h8100_f700, 32'h8200_ff00, 32'h8300_ff00,
    32'h8400_ff00, 32'h8500_ff00, 32'h8600_fe00, 32'h8a00_ff00,
    32'h8b00_ff00, 32'h8c00_ff00, 32'h8d00_ff00, 32'h8e00_ff00,
    32'h8f00_ff00,
    32'h9000_f700, 32'h9100_f700, 32'h9200_f600, 32'h9400_f600,
    32'h9600_f600,
    32'ha000_e700, 32'ha100_f700, 32'ha200_e600, 32'ha400_e600,
    32'ha600_e600, 32'hb100_f700,
    32'hc000_e700, 32'hc100_e700, 32'hc200_e600, 32'hc400_e600,
    32'hc600_e600,
    32'he000_fc00, 32'he400_fc00, 32'he800_fc00, 32'hec00_fc00,
    32'hf000_fe00, 32'hf200_fe00, 32'hf400_fe00, 32'hf600_fe00,
    32'hf800_fc00, 32'hfc00_fe00, 32'hfe00_fe00
  };

  localparam logic [31:0] ExtRules [25] = '{
    32'h0000_00fc, 32'h0004_00fc, 32'h0008_00fc, 32'h000c_00fc,
    32'h0010_00f0, 32'h0020_00e4, 32'h0024_00e4, 32'h0040_00c4,
    32'h0044_00c4, 32'h0080_00ce, 32'h0082_00ce, 32'h0084_00ce,
    32'h0086_00ce, 32'h0088_00ce, 32'h008a_00ce, 32'h008c_00ce,
    32'h008e_00ce, 32'h00c3_00cf, 32'h00c7_00cf, 32'h00cb_00cf,
    32'h00cf_00cf, 32'h00c0_00cc, 32'h00c4_00cc, 32'h00c8_00cc,
    32'h00cc_00cc
  };

  localparam logic [15:0] DirectedWords [22] = '{
    16'h0000, 16'hffff, 16'h0021, 16'h0020, 16'h0001, 16'h02ca,
    16'h02cb, 16'h3000, 16'h3fff, 16'h30ff, 16'h307f, 16'h3080,
    16'h00ff, 16'h00cf, 16'h00c3, 16'h8000, 16'hb100, 16'hfe00,
    16'hfffe, 16'h7fff, 16'h1710, 16'h14c0
  };

  class DecodeScoreboard;
    decode_t expected_decodes[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function decode_t decode_word(logic [InstW-1:0] word);
      decode_t         d;
      logic [15:0] ext_bits;
      d = '0;
      d.seven_bit = (word[15:12] == 4'h3);
      ext_bits = {8'h00, word[7] & ~d.seven_bit, word[6:0]};
      for (int k = 124; k >= 0; k--) begin
        if ((word & MainRules[k][15:0]) == MainRules[k][31:16]) begin
          d.main_entry   = MainIdxW'(k);
          d.main_matched = 1'b1;
        end
      end
      for (int k = 24; k >= 0; k--) begin
        if ((ext_bits & ExtRules[k][15:0]) == ExtRules[k][31:16]) begin
          d.ext_entry   = ExtIdxW'(k);
          d.ext_matched = 1'b1;
        end
      end
      return d;
    endfunction

    function void note_instruction(logic [InstW-1:0] word);
      expected_decodes.push_back(decode_word(word));
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction

    function void check_decode(decode_t got);
      decode_t want;
      if (expected_decodes.size() == 0) begin
        if (errors < 10) $display("unexpected result beat: %p", got);
        errors++;
      end else begin
        want = expected_decodes.pop_front();
        if (got.main_entry !== want.main_entry || got.main_matched !== want.main_matched ||
            got.ext_entry !== want.ext_entry || got.ext_matched !== want.ext_matched ||
            got.seven_bit !== want.seven_bit) begin
          if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [InstW-1:0]    instruction_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [MainIdxW-1:0] main_entry_o;
  logic                main_matched_o;
  logic [ExtIdxW-1:0]  ext_entry_o;
  logic                ext_matched_o;
  logic                seven_bit_ext_o;

  bit              hold_request = 1'b0;
  DecodeScoreboard board;

  dsp_opcode_mask_match_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instruction_i  (instruction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .main_entry_o   (main_entry_o),
    .main_matched_o (main_matched_o),
    .ext_entry_o    (ext_entry_o),
    .ext_matched_o  (ext_matched_o),
    .seven_bit_ext_o(seven_bit_ext_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_instruction(instruction_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_decode(decode_t'{main_entry_o, main_matched_o, ext_entry_o,
                                     ext_matched_o, seven_bit_ext_o});
      end
    end
  end

  initial begin
    int   stall_mode;
    int   mode_left;
    int   hold_left;
    int   phase;
    logic stall;
    stall_mode = 0;
    mode_left  = 0;
    hold_left  = 0;
    phase      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = 60;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        stall = 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 3) == 0);
          2: stall = ($urandom_range(0, 3) != 0);
          default: stall = ((phase % 5) < 2);
        endcase
      end
      out_stall_i <= stall;
    end
  end

  task automatic drive_word(input logic [InstW-1:0] word);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    instruction_i <= word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(input int count);
    repeat (count) begin
      @(negedge clk_i);
      in_valid_i    <= 1'b0;
      instruction_i <= InstW'($urandom);
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [InstW-1:0] pick_word();
    logic [15:0] noise;
    logic [31:0] rule;
    logic [15:0] word;
    int          sel;
    noise = 16'($urandom);
    word  = 16'($urandom);
    sel   = $urandom_range(0, 9);
    if (sel < 4) begin
      rule = MainRules[$urandom_range(0, 124)];
      word = (rule[31:16] & rule[15:0]) | (noise & ~rule[15:0]);
    end else if (sel < 7) begin
      rule = ExtRules[$urandom_range(0, 24)];
      word[7:0] = (rule[23:16] & rule[7:0]) | (noise[7:0] & ~rule[7:0]);
      if ($urandom_range(0, 1) == 1) word[15:12] = 4'h3;
    end
    return word;
  endfunction

  initial begin
    int sent;
    int burst;
    bit hold_done;
    bit pause_done;
    board      = new();
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (DirectedWords[i]) drive_word(DirectedWords[i]);
    idle_cycles(1);

    while (sent < 1300) begin
      if (!hold_done && sent >= 500) begin
        // The receiver holds off long enough for the pipeline to fill and
        // push back on the sender, which keeps offering beats throughout.
        hold_done    = 1'b1;
        hold_request = 1'b1;
        repeat (40) begin
          drive_word(pick_word());
          sent++;
        end
      end
      if (!pause_done && sent >= 900) begin
        pause_done = 1'b1;
        wait_drained();
      end
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        drive_word(pick_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
src/omd_pkg.sv
src/omd_prio_enc.sv
src/dsp_opcode_mask_match_decoder.sv
sim/tb_dsp_opcode_mask_match_decoder.sv
